/* rtl/core/mexp_pkg.sv */
`default_nettype none

package mexp_pkg;

    localparam int MEXP_EXP_WIDTH = 63;
    localparam int MEXP_MOD_WIDTH = 31;
    localparam int BASE_WIDTH     = 63;
    localparam int STEP_W         = $clog2(BASE_WIDTH + 1);

    localparam logic [30:0] MOD_RESET = 31'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_BIT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } mexp_state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } mexp_unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mexp_unit_sts_t;

endpackage

`default_nettype wire

/* rtl/core/mexp_mulmod.sv */
`default_nettype none

module mexp_mulmod #(
    parameter int MOD_WIDTH = mexp_pkg::MEXP_MOD_WIDTH
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  mexp_pkg::mexp_unit_ctl_t        ctl,
    input  wire  [MOD_WIDTH-1:0]            modulus,
    input  wire  [MOD_WIDTH-1:0]            addend_in,
    input  wire  [mexp_pkg::BASE_WIDTH-1:0] scan_in,
    output mexp_pkg::mexp_unit_sts_t        sts,
    output logic [MOD_WIDTH-1:0]            product
);
    import mexp_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     cnt_reg;
    logic [MOD_WIDTH-1:0]  acc_reg;
    logic [MOD_WIDTH-1:0]  acc_next;
    logic [MOD_WIDTH-1:0]  a_reg;
    logic [BASE_WIDTH-1:0] scan_reg;

    logic [MOD_WIDTH:0] mod_ext;
    logic [MOD_WIDTH:0] dbl;
    logic [MOD_WIDTH:0] dbl_red;
    logic [MOD_WIDTH:0] sum;
    logic [MOD_WIDTH:0] sum_red;

    // one step: acc = (2*acc + bit*a) mod m, scanning the operand from its top bit
    always_comb
    begin
        mod_ext  = {1'b0, modulus};
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
        sum      = dbl_red + (scan_reg[BASE_WIDTH-1] ? {1'b0, a_reg} : '0);
        sum_red  = (sum >= mod_ext) ? (sum - mod_ext) : sum;
        acc_next = sum_red[MOD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctl.steps;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == STEP_W'(1));
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg  <= '0;
            a_reg    <= addend_in;
            scan_reg <= scan_in;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            scan_reg <= {scan_reg[BASE_WIDTH-2:0], 1'b0};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = acc_reg;

endmodule

`default_nettype wire

/* rtl/core/modular_exponentiation_top.sv */
`default_nettype none

// Channel   Handshake                  Payload
// input     in_valid / in_ready        req_type, base_value, exponent_value
// output    out_valid / out_ready      result_value
// config    cfg_write_en               cfg_write_data (modulus)
//
// One request at a time through a bit-serial modular multiply-add unit.
// Base reduction first, then for each exponent bit up to the top set one: a
// multiply for a one bit, then a square for every bit below the top one.
// A zero base or zero exponent goes straight to the result, skipping the unit.
// Reset loads modulus 1000000007. The result waits in an output register, so
// in_ready returns before out_ready; a second result stalls until it drains.

module modular_exponentiation_top #(
    parameter int EXP_WIDTH = mexp_pkg::MEXP_EXP_WIDTH,
    parameter int MOD_WIDTH = mexp_pkg::MEXP_MOD_WIDTH
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire                             req_type,
    input  wire  [mexp_pkg::BASE_WIDTH-1:0] base_value,
    input  wire  [EXP_WIDTH-1:0]            exponent_value,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [MOD_WIDTH-1:0]            result_value,
    input  wire                             cfg_write_en,
    input  wire  [MOD_WIDTH-1:0]            cfg_write_data
);
    import mexp_pkg::*;

    localparam int EREG_W = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;

    mexp_state_t state_reg;
    mexp_state_t state_next;

    logic [MOD_WIDTH-1:0] mod_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] sq_reg;
    logic [EREG_W-1:0]    exp_reg;
    logic [MOD_WIDTH-1:0] res_reg;
    logic                 out_valid_reg;
    logic [MOD_WIDTH-1:0] out_data_reg;

    mexp_unit_ctl_t        unit_ctl;
    mexp_unit_sts_t        unit_sts;
    logic [MOD_WIDTH-1:0]  unit_addend;
    logic [BASE_WIDTH-1:0] unit_scan;
    logic [MOD_WIDTH-1:0]  unit_product;

    logic              accept;
    logic              mod_zero;
    logic              mod_one;
    logic              mod_small;
    logic [EREG_W-1:0] exp_eff;
    logic              zero_res;
    logic              one_res;
    logic              exp_more;
    logic              load_out;

    always_comb
    begin
        accept    = in_valid && in_ready;
        mod_zero  = (mod_reg == '0);
        mod_one   = (mod_reg == MOD_WIDTH'(1));
        mod_small = (mod_reg[MOD_WIDTH-1:1] == '0);
        exp_eff   = req_type ? EREG_W'(mod_reg - MOD_WIDTH'(2)) : EREG_W'(exponent_value);
        zero_res  = (req_type && mod_small) || (base_value == '0) || mod_zero;
        one_res   = (exp_eff == '0);
        exp_more  = (exp_reg[EREG_W-1:1] != '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (zero_res || one_res) ? ST_DONE : ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (unit_sts.done)
                    state_next = ST_BIT;
            end
            ST_BIT:
            begin
                if (exp_reg[0])
                    state_next = ST_MUL;
                else if (exp_more)
                    state_next = ST_SQR;
                else
                    state_next = ST_DONE;
            end
            ST_MUL, ST_SQR:
            begin
                if (unit_sts.done)
                    state_next = ST_BIT;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and unit control
    always_comb
    begin
        in_ready       = 1'b0;
        load_out       = 1'b0;
        unit_ctl.start = 1'b0;
        unit_ctl.steps = STEP_W'(MOD_WIDTH);
        unit_addend    = sq_reg;
        unit_scan      = {sq_reg, {(BASE_WIDTH - MOD_WIDTH){1'b0}}};
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && !zero_res && !one_res)
                begin
                    // reduce the base: scan all its bits with addend one
                    unit_ctl.start = 1'b1;
                    unit_ctl.steps = STEP_W'(BASE_WIDTH);
                    unit_addend    = MOD_WIDTH'(1);
                    unit_scan      = base_value;
                end
            end
            ST_BIT:
            begin
                if (exp_reg[0])
                begin
                    unit_ctl.start = 1'b1;
                    unit_addend    = acc_reg;
                end
                else if (exp_more)
                    unit_ctl.start = 1'b1;
            end
            ST_DONE:
                load_out = !out_valid_reg || out_ready;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= MOD_WIDTH'(MOD_RESET);
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_write_en)
                mod_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    exp_reg <= exp_eff;
                    acc_reg <= mod_one ? '0 : MOD_WIDTH'(1);
                    res_reg <= zero_res ? '0 : MOD_WIDTH'(1);
                end
            end
            ST_REDUCE:
            begin
                if (unit_sts.done)
                    sq_reg <= unit_product;
            end
            ST_BIT:
            begin
                if (!exp_reg[0] && !exp_more)
                    res_reg <= acc_reg;
            end
            ST_MUL:
            begin
                if (unit_sts.done)
                begin
                    acc_reg    <= unit_product;
                    exp_reg[0] <= 1'b0;
                end
            end
            ST_SQR:
            begin
                if (unit_sts.done)
                begin
                    sq_reg  <= unit_product;
                    exp_reg <= {1'b0, exp_reg[EREG_W-1:1]};
                end
            end
            default:
                ;
        endcase
    end

    mexp_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_mulmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (unit_ctl),
        .modulus   (mod_reg),
        .addend_in (unit_addend),
        .scan_in   (unit_scan),
        .sts       (unit_sts),
        .product   (unit_product)
    );

    assign out_valid    = out_valid_reg;
    assign result_value = out_data_reg;

    a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !unit_sts.busy)
        else $error("request taken while the multiply unit is busy");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after a request was taken");

    a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BIT) |-> ((acc_reg < mod_reg) && (sq_reg < mod_reg)))
        else $error("operand not reduced below the modulus");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        unit_sts.done |->
            (state_reg == ST_REDUCE || state_reg == ST_MUL || state_reg == ST_SQR))
        else $error("multiply unit finished with no operation pending");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result shown without a finished computation");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int PHASE_COUNT     = 10;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int PRESSURE_PHASE  = 0;
    localparam int LONG_HOLD       = 2000;
    localparam int WATCHDOG_LIMIT  = 50000;
    localparam int TAIL_CYCLES     = 40;
    localparam int MAX_REPORTS     = 100;
    localparam int DIRECTED_COUNT  = 25;

    localparam logic REQ_POWER   = 1'b0;
    localparam logic REQ_INVERSE = 1'b1;
    localparam logic KNOWN       = 1'b1;
    localparam logic PREDICT     = 1'b0;

    localparam logic [62:0] MAX63     = 63'h7fff_ffff_ffff_ffff;
    localparam logic [30:0] PRIME31   = 31'h7fff_ffff;
    localparam logic [30:0] MOD_RESET = mexp_pkg::MOD_RESET;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [30:0] modulus;
        logic        inv;
        logic [62:0] base;
        logic [62:0] expo;
        logic        fixed;
        logic [30:0] fixed_value;
    } directed_row_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        req_type       = REQ_POWER;
    logic [62:0] base_value     = '0;
    logic [62:0] exponent_value = '0;
    logic        out_ready      = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [30:0] cfg_write_data = '0;
    logic        in_ready;
    logic        out_valid;
    logic [30:0] result_value;

    logic [30:0] modulus_setting = MOD_RESET;
    idle_mode_t  idle_mode       = IDLE_NONE;
    logic [30:0] pending_residues [$];
    int unsigned hold_requests_made = 0;
    int unsigned requests_sent      = 0;
    int unsigned inverses_sent      = 0;
    int unsigned results_checked    = 0;
    int unsigned modulus_writes     = 0;
    int unsigned errors             = 0;

    int unsigned sender_gap_pct   [4] = '{0, 85, 0, 26};
    int unsigned receiver_stall_pct [4] = '{0, 0, 85, 26};

    directed_row_t directed_rows [DIRECTED_COUNT] = '{
        '{MOD_RESET, REQ_POWER,   63'd0,          63'd0,          KNOWN,   31'd0},
        '{MOD_RESET, REQ_POWER,   63'd0,          MAX63,          KNOWN,   31'd0},
        '{MOD_RESET, REQ_POWER,   63'd5,          63'd0,          KNOWN,   31'd1},
        '{MOD_RESET, REQ_POWER,   MAX63,          63'd0,          KNOWN,   31'd1},
        '{MOD_RESET, REQ_POWER,   63'd1,          MAX63,          KNOWN,   31'd1},
        '{MOD_RESET, REQ_POWER,   63'd2,          63'd10,         KNOWN,   31'd1024},
        '{MOD_RESET, REQ_POWER,   MAX63,          MAX63,          PREDICT, 31'd0},
        '{MOD_RESET, REQ_POWER,   63'd1000000007, 63'd0,          KNOWN,   31'd1},
        '{MOD_RESET, REQ_POWER,   63'd2000000014, 63'd3,          KNOWN,   31'd0},
        '{MOD_RESET, REQ_INVERSE, 63'd2,          MAX63,          PREDICT, 31'd0},
        '{MOD_RESET, REQ_INVERSE, 63'd0,          63'd0,          KNOWN,   31'd0},
        '{MOD_RESET, REQ_INVERSE, MAX63,          63'd0,          PREDICT, 31'd0},
        '{PRIME31,   REQ_POWER,   MAX63,          MAX63,          PREDICT, 31'd0},
        '{PRIME31,   REQ_INVERSE, 63'h7ffffffe,   63'd0,          PREDICT, 31'd0},
        '{PRIME31,   REQ_POWER,   63'd3,          63'h7fffffff,   PREDICT, 31'd0},
        '{31'd1,     REQ_POWER,   63'd7,          63'd0,          KNOWN,   31'd1},
        '{31'd1,     REQ_POWER,   63'd7,          63'd5,          KNOWN,   31'd0},
        '{31'd1,     REQ_INVERSE, 63'd7,          63'd0,          KNOWN,   31'd0},
        '{31'd1,     REQ_POWER,   63'd0,          63'd0,          KNOWN,   31'd0},
        '{31'd2,     REQ_INVERSE, 63'd3,          63'd0,          KNOWN,   31'd1},
        '{31'd2,     REQ_INVERSE, 63'd0,          63'd0,          KNOWN,   31'd0},
        '{31'd2,     REQ_POWER,   63'd3,          MAX63,          KNOWN,   31'd1},
        '{31'd13,    REQ_INVERSE, 63'd5,          63'd0,          PREDICT, 31'd0},
        '{31'd13,    REQ_POWER,   63'd13,         63'd0,          KNOWN,   31'd1},
        '{31'd13,    REQ_POWER,   63'd26,         63'd2,          KNOWN,   31'd0}
    };

    modular_exponentiation_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_value   (result_value),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic bit roll(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [62:0] random_word63();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[62:0];
    endfunction

    // Square-and-multiply residue; an inverse raises the base to modulus - 2.
    function automatic logic [30:0] power_mod(input logic inv, input logic [62:0] b,
                                              input logic [62:0] e, input logic [30:0] m);
        longint unsigned mm;
        longint unsigned rest;
        longint unsigned sq;
        longint unsigned acc;
        mm = 64'(m);
        if (inv) begin
            if (mm < 64'd2)
                return 31'd0;
            rest = mm - 64'd2;
        end
        else
            rest = 64'(e);
        if (b == 63'd0 || mm == 64'd0)
            return 31'd0;
        // Nonzero base with zero exponent gives a raw 1, whatever the modulus
        if (rest == 64'd0)
            return 31'd1;
        sq  = 64'(b) % mm;
        acc = 64'd1 % mm;
        while (rest != 64'd0) begin
            if ((rest & 64'd1) != 64'd0)
                acc = (acc * sq) % mm;
            sq   = (sq * sq) % mm;
            rest = rest >> 1;
        end
        return acc[30:0];
    endfunction

    task automatic send_request(input logic inv, input logic [62:0] b, input logic [62:0] e,
                                input logic fixed, input logic [30:0] fixed_value);
        if (roll(sender_gap_pct[idle_mode])) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (roll(sender_gap_pct[idle_mode]));
        end
        in_valid       <= 1'b1;
        req_type       <= inv;
        base_value     <= b;
        exponent_value <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_residues.push_back(fixed ? fixed_value : power_mod(inv, b, e, modulus_setting));
        requests_sent++;
        if (inv == REQ_INVERSE)
            inverses_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_residues.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(input logic [30:0] m);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(posedge clk);
        cfg_write_en    <= 1'b0;
        modulus_setting = m;
        modulus_writes++;
    endtask

    task automatic make_random_request(output logic inv, output logic [62:0] b,
                                       output logic [62:0] e);
        int unsigned pick;
        int unsigned bits;
        longint unsigned factor;
        pick = $urandom_range(99);
        // Inverses are cheap only under a short modulus
        inv  = (modulus_setting < 31'd65536) ? (pick < 25) : (pick < 3);
        pick = $urandom_range(99);
        if (pick < 5)
            b = 63'd0;
        else if (pick < 10) begin
            factor = 64'($urandom_range(1000, 1));
            b = 63'(factor * 64'(modulus_setting));
        end
        else if (pick < 16)
            b = 63'($urandom_range(20, 1));
        else if (pick < 20)
            b = MAX63 - 63'($urandom_range(3));
        else
            b = random_word63();
        pick = $urandom_range(99);
        if (pick < 5)
            e = 63'd0;
        else if (pick < 6)
            e = random_word63();
        else begin
            // Keep most exponents short: every bit costs a square, and a one bit a multiply too
            bits = $urandom_range(8, 1);
            e = random_word63() & ((63'd1 << bits) - 63'd1);
        end
    endtask

    initial begin : result_checker
        int unsigned hold_left;
        int unsigned holds_served;
        logic [30:0] want;
        hold_left = 0;
        holds_served = 0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                results_checked++;
                if (pending_residues.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result_value %0d with no request outstanding",
                                 $time, result_value);
                end
                else begin
                    want = pending_residues.pop_front();
                    if (result_value !== want) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: result_value expected %0d actual %0d",
                                     $time, want, result_value);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (holds_served != hold_requests_made) begin
                // Hold the output off so the block fills and stalls its input
                holds_served++;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !roll(receiver_stall_pct[idle_mode]);
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial begin : stimulus
        logic [30:0] phase_moduli [PHASE_COUNT];
        logic        inv;
        logic [62:0] b;
        logic [62:0] e;
        phase_moduli = '{PRIME31, 31'd1, 31'd2, 31'd13, 31'd65521, MOD_RESET,
                         31'd0, 31'd0, PRIME31, 31'd3};
        phase_moduli[6] = 31'($urandom_range(32'h7fff_ffff, 1));
        phase_moduli[7] = 31'($urandom_range(255, 3));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows start under the reset modulus
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            if (directed_rows[i].modulus != modulus_setting) begin
                drain_results();
                write_modulus(directed_rows[i].modulus);
            end
            send_request(directed_rows[i].inv, directed_rows[i].base, directed_rows[i].expo,
                         directed_rows[i].fixed, directed_rows[i].fixed_value);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            write_modulus(phase_moduli[p]);
            idle_mode = idle_mode_t'(p % 4);
            if (p == PRESSURE_PHASE)
                hold_requests_made++;
            repeat (ITEMS_PER_PHASE) begin
                make_random_request(inv, b, e);
                send_request(inv, b, e, PREDICT, 31'd0);
            end
        end

        drain_results();
        // Allow for a stray late result
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d inverses) under %0d modulus writes, idle and stall mixes;",
                 requests_sent, inverses_sent, modulus_writes);
        $display("compared %0d results, %0d errors.", results_checked, errors);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mexp_pkg.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation_top.sv
tb/tb_top.sv
